FILE: rtl/mnd_pkg.sv
// Package for the MIDI note-on detector.
// Holds the MIDI byte codes, the parser state type and the system message length table.
// No dependencies.
`timescale 1ns / 1ps

package mnd_pkg;

  localparam logic [7:0] STATUS_MASK   = 8'h80;
  localparam logic [7:0] SYSEX_START   = 8'hF0;
  localparam logic [7:0] SYSEX_END     = 8'hF7;
  localparam logic [7:0] HI_NOTE_ON    = 8'h90;
  localparam logic [7:0] HI_PROG_CHG   = 8'hC0;
  localparam logic [7:0] HI_CHAN_PRESS = 8'hD0;
  localparam logic [7:0] HI_MASK       = 8'hF0;
  localparam logic [7:0] CHAN_MASK     = 8'h0F;

  localparam logic [7:0] SYS_MTC_QF    = 8'hF1;
  localparam logic [7:0] SYS_SONG_POS  = 8'hF2;
  localparam logic [7:0] SYS_SONG_SEL  = 8'hF3;
  localparam logic [7:0] SYS_TUNE_REQ  = 8'hF6;
  localparam logic [7:0] RT_CLOCK      = 8'hF8;
  localparam logic [7:0] RT_START      = 8'hFA;
  localparam logic [7:0] RT_CONTINUE   = 8'hFB;
  localparam logic [7:0] RT_STOP       = 8'hFC;
  localparam logic [7:0] RT_SENSE      = 8'hFE;
  localparam logic [7:0] RT_RESET      = 8'hFF;

  localparam int          CHAN_W        = 5;
  localparam logic [0:0]  REG_LISTEN    = 1'b0;
  localparam logic [CHAN_W-1:0] LISTEN_RESET = 5'd1;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_SYSEX = 3'b010,
    MODE_MSG   = 3'b100
  } mode_t;

  // Total length of a system message; zero marks an undefined code or a SysEx start or end byte.
  function automatic logic [1:0] system_length(input logic [7:0] b);
    logic [1:0] len;
    len = 2'd0;
    case (b) inside
      SYS_MTC_QF, SYS_SONG_SEL: len = 2'd2;
      SYS_SONG_POS:             len = 2'd3;
      SYS_TUNE_REQ, RT_CLOCK, RT_START, RT_CONTINUE, RT_STOP, RT_SENSE, RT_RESET:
                                len = 2'd1;
      default:                  len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/midi_note_on_detector.sv
// Top level of the MIDI note-on detector: byte parser, output register with skid stage, APB port.
// Depends on mnd_pkg.
// The result item for an accepted byte goes into the output register, or into the skid stage while the output is held.
// Throughput: one byte per cycle while the skid stage is empty; the parser state updates in a single pass per byte.
// A skid stage lets a byte be accepted while the previous result still waits.
// Reset clears the parser to idle, empties the output stages and sets listen_channel to 1.
`timescale 1ns / 1ps

module midi_note_on_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] velocity
  output logic        m_tuser,   // [0] note_on
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [mnd_pkg::CHAN_W-1:0] listen_channel;
  mnd_pkg::mode_t mode, mode_next;
  logic [1:0] bytes_left, bytes_left_next, bytes_dec, len;
  logic       cand, cand_next;
  logic       hit;
  logic [7:0] vel;
  logic [7:0] hi;
  logic       in_acc;
  logic       skid_valid;
  logic [7:0] skid_tdata;
  logic       skid_tuser;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mnd_pkg::REG_LISTEN) ?
                  {{(32-mnd_pkg::CHAN_W){1'b0}}, listen_channel} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_channel <= mnd_pkg::LISTEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == mnd_pkg::REG_LISTEN) begin
      listen_channel <= pwdata[mnd_pkg::CHAN_W-1:0];
    end
  end

  assign in_acc = s_tvalid && s_tready;
  assign hi     = s_tdata & mnd_pkg::HI_MASK;
  assign bytes_dec = bytes_left - 2'd1;

  always_comb begin
    mode_next       = mode;
    bytes_left_next = bytes_left;
    cand_next       = cand;
    hit             = 1'b0;
    vel             = 8'd0;
    len             = 2'd0;
    unique case (mode)
      mnd_pkg::MODE_SYSEX: begin
        if (s_tdata == mnd_pkg::SYSEX_END) begin
          mode_next       = mnd_pkg::MODE_IDLE;
          bytes_left_next = 2'd0;
          cand_next       = 1'b0;
        end
      end
      mnd_pkg::MODE_MSG: begin
        bytes_left_next = bytes_dec;
        if (bytes_dec == 2'd0) begin
          if (cand && s_tdata != 8'd0) begin
            hit = 1'b1;
            vel = s_tdata;
          end
          mode_next = mnd_pkg::MODE_IDLE;
          cand_next = 1'b0;
        end
      end
      default: begin
        if ((s_tdata & mnd_pkg::STATUS_MASK) != 8'd0) begin
          if (s_tdata == mnd_pkg::SYSEX_START) begin
            mode_next = mnd_pkg::MODE_SYSEX;
          end else if (s_tdata > mnd_pkg::SYSEX_START) begin
            len = mnd_pkg::system_length(s_tdata);
            if (len > 2'd1) begin
              mode_next       = mnd_pkg::MODE_MSG;
              bytes_left_next = len - 2'd1;
              cand_next       = 1'b0;
            end else begin
              mode_next       = mnd_pkg::MODE_IDLE;
              bytes_left_next = 2'd0;
              cand_next       = 1'b0;
            end
          end else begin
            mode_next       = mnd_pkg::MODE_MSG;
            bytes_left_next = (hi == mnd_pkg::HI_PROG_CHG || hi == mnd_pkg::HI_CHAN_PRESS) ?
                              2'd1 : 2'd2;
            cand_next       = (hi == mnd_pkg::HI_NOTE_ON) &&
                              ({1'b0, s_tdata[3:0]} + 5'd1 == listen_channel);
          end
        end else begin
          mode_next       = mnd_pkg::MODE_IDLE;
          bytes_left_next = 2'd0;
          cand_next       = 1'b0;
        end
      end
    endcase
    if (s_tlast) begin
      mode_next       = mnd_pkg::MODE_IDLE;
      bytes_left_next = 2'd0;
      cand_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= mnd_pkg::MODE_IDLE;
      bytes_left <= 2'd0;
      cand       <= 1'b0;
    end else if (in_acc) begin
      mode       <= mode_next;
      bytes_left <= bytes_left_next;
      cand       <= cand_next;
    end
  end

  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (m_tready) begin
          m_tvalid   <= 1'b1;
          m_tdata    <= skid_tdata;
          m_tuser    <= skid_tuser;
          skid_valid <= 1'b0;
        end
      end else if (in_acc) begin
        if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          m_tdata  <= vel;
          m_tuser  <= hit;
        end else begin
          skid_valid <= 1'b1;
          skid_tdata <= vel;
          skid_tuser <= hit;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_vel_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 8'd0)
    else $error("velocity nonzero without note_on");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> mode == mnd_pkg::MODE_IDLE && bytes_left == 2'd0 && !cand)
    else $error("parser state not cleared after packet end");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid stage holds an item while output is empty");

  a_msg_count: assert property (@(posedge clk) disable iff (rst)
    mode == mnd_pkg::MODE_MSG |-> bytes_left != 2'd0)
    else $error("open message with no bytes owed");

endmodule
